>>> rtl/core/fqsr_pkg.sv
// ---------------------------------------------------------------------------
// fqsr_pkg: shared types and constants for the handle queue
// Sizes of the queue, request kind codes and the control bundle that the
// queue controller hands to every storage cell.
// ---------------------------------------------------------------------------
package fqsr_pkg;

  // Queue geometry
  localparam int unsigned Depth    = 16;
  localparam int unsigned HandleW  = 32;
  localparam int unsigned CountW   = $clog2(Depth + 1);
  localparam int unsigned KindW    = 2;
  localparam int unsigned OutDataW = 40;

  // Request kinds
  typedef enum logic [KindW-1:0] {
    KIND_APPEND = 2'd0,
    KIND_POP    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_FIND   = 2'd3
  } kind_e;

  typedef logic [HandleW-1:0] handle_t;
  typedef logic [CountW-1:0]  count_t;

  // Control common to all cells
  typedef struct packed {
    logic    cmp_en;     // latch key compare result
    handle_t cmp_key;    // key compared on accept
    handle_t wr_key;     // key written at the tail
    logic    shift_pop;  // every cell takes its upper neighbor
    logic    shift_rm;   // cells from the first hit up take their neighbor
  } cell_ctrl_t;

endpackage

>>> rtl/core/fifo_queue_with_search_remove_core.sv
// ---------------------------------------------------------------------------
// fifo_queue_with_search_remove_core: ordered handle queue with delete-by-key
// Sixteen-slot FIFO of handles supporting append, pop-front, remove of the
// first matching handle, and find. One result per request.
// ---------------------------------------------------------------------------
// Each request runs through S_IDLE and S_EXEC: in the accept cycle every slot
// compares its handle to the key in parallel; in S_EXEC, once the result register
// is free, a first-hit chain through the slot row picks the entry to delete, the
// slots above it shift down one place, and the result is loaded into the output
// register. A new request is accepted while a result still waits on the output; a
// stalled output holds S_EXEC until the result register frees up. Slot 0 is the head.
// Appending to a full queue, popping an empty one, or removing an absent
// handle leaves the queue unchanged and returns ok = 0.
module fifo_queue_with_search_remove_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Request stream
  input  logic                   s_tvalid_i,
  output logic                   s_tready_o,
  input  logic [31:0]            s_tdata_i,   // [31:0] handle
  input  logic [1:0]             s_tuser_i,   // [1:0] kind
  // Result stream
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  output logic [39:0]            m_tdata_o    // [31:0] popped_handle, [32] ok,
                                              // [37:33] entry_count, [39:38] zero
);
  import fqsr_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e     state_q;
  kind_e      kind_q;
  handle_t    key_q;
  count_t     count_q;
  logic       out_valid_q;
  handle_t    popped_q;
  logic       ok_q;
  count_t     out_count_q;

  cell_ctrl_t ctrl;
  logic       accept;
  logic       go;
  logic       found;
  logic       not_full;
  logic       not_empty;
  logic       op_ok;
  count_t     count_d;

  handle_t    entry   [Depth];
  logic       hit     [Depth+1];
  logic       live    [Depth];
  logic       tail_wr [Depth];

  assign s_tready_o = (state_q == S_IDLE);
  assign accept     = s_tvalid_i & s_tready_o;
  assign go         = (state_q == S_EXEC) & (~out_valid_q | m_tready_i);

  assign not_full  = (count_q < count_t'(Depth));
  assign not_empty = (count_q != '0);
  assign found     = hit[Depth];

  // Control to the slot row
  always_comb begin
    ctrl.cmp_en    = accept;
    ctrl.cmp_key   = s_tdata_i[HandleW-1:0];
    ctrl.wr_key    = key_q;
    ctrl.shift_pop = go & (kind_q == KIND_POP) & not_empty;
    ctrl.shift_rm  = go & (kind_q == KIND_REMOVE);
  end

  // Slot row
  assign hit[0] = 1'b0;
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    localparam count_t Idx = count_t'(g);
    handle_t next_entry;

    assign live[g]    = (Idx < count_q);
    assign tail_wr[g] = go & (kind_q == KIND_APPEND) & not_full & (count_q == Idx);

    if (g == Depth - 1) begin : g_top
      assign next_entry = '0;
    end else begin : g_mid
      assign next_entry = entry[g+1];
    end

    fqsr_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .live_i    (live[g]),
      .tail_wr_i (tail_wr[g]),
      .next_i    (next_entry),
      .hit_i     (hit[g]),
      .hit_o     (hit[g+1]),
      .entry_o   (entry[g])
    );
  end

  // Outcome and new count
  always_comb begin
    op_ok   = 1'b0;
    count_d = count_q;
    unique case (kind_q)
      KIND_APPEND: begin
        op_ok = not_full;
        if (not_full) count_d = count_q + count_t'(1);
      end
      KIND_POP: begin
        op_ok = not_empty;
        if (not_empty) count_d = count_q - count_t'(1);
      end
      KIND_REMOVE: begin
        op_ok = found;
        if (found) count_d = count_q - count_t'(1);
      end
      KIND_FIND: begin
        op_ok = found;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  // Sequencer, count and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      popped_q    <= '0;
      ok_q        <= 1'b0;
      out_count_q <= '0;
    end else begin
      // loaded by a finished request, freed when the sink takes it
      out_valid_q <= go | (out_valid_q & ~m_tready_i);
      unique case (state_q)
        S_IDLE: begin
          if (accept) state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (go) begin
            count_q     <= count_d;
            popped_q    <= ((kind_q == KIND_POP) && not_empty) ? entry[0] : '0;
            ok_q        <= op_ok;
            out_count_q <= count_d;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Request payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_e'(s_tuser_i);
      key_q  <= s_tdata_i[HandleW-1:0];
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {2'b00, out_count_q, ok_q, popped_q};

endmodule

>>> rtl/core/fqsr_cell.sv
// ---------------------------------------------------------------------------
// fqsr_cell: one queue slot
// Holds one handle, compares it to the request key, and takes part in the
// first-hit chain that picks the slot to delete. Shifts in its upper
// neighbor's handle to close a gap.
// ---------------------------------------------------------------------------
module fqsr_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fqsr_pkg::cell_ctrl_t ctrl_i,
  input  logic                live_i,     // slot holds a queued handle
  input  logic                tail_wr_i,  // slot is the append target
  input  fqsr_pkg::handle_t   next_i,     // handle of the upper neighbor
  input  logic                hit_i,      // a lower slot already matched
  output logic                hit_o,
  output fqsr_pkg::handle_t   entry_o
);
  import fqsr_pkg::*;

  handle_t entry_q;
  logic    match_q;
  logic    shift;

  // First-hit chain: this slot and all above it close the gap
  assign hit_o = hit_i | (match_q & live_i);
  assign shift = ctrl_i.shift_pop | (ctrl_i.shift_rm & hit_o);
  assign entry_o = entry_q;

  // Compare result, taken in the accept cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      match_q <= (entry_q == ctrl_i.cmp_key);
    end
  end

  // Slot data
  always_ff @(posedge clk_i) begin
    if (tail_wr_i) begin
      entry_q <= ctrl_i.wr_key;
    end else if (shift) begin
      entry_q <= next_i;
    end
  end

endmodule

>>> tb/fqsr_queue_checker.sv
// ---------------------------------------------------------------------------
// fqsr_queue_checker: result checker for the handle queue
// Watches the request and result streams, keeps its own copy of the queue
// contents, works out the result of every accepted request and compares each
// accepted result field by field with the oldest one still outstanding.
// ---------------------------------------------------------------------------
module fqsr_queue_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request stream, observed
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [31:0]                   s_tdata_i,    // [31:0] handle
  input  logic [1:0]                    s_tuser_i,    // [1:0] kind
  // Result stream, observed
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [fqsr_pkg::OutDataW-1:0] m_tdata_i,    // [31:0] popped_handle, [32] ok,
                                                      // [37:33] entry_count, [39:38] zero
  // Status to the test top
  output int unsigned                   err_cnt_o,
  output int unsigned                   pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import fqsr_pkg::*;

  typedef struct packed {
    handle_t popped;
    logic    ok;
    count_t  count;
  } queue_result_t;

  handle_t       held_handles[$];     // queue contents, head first
  queue_result_t due_results[$];      // results still owed by the block
  int unsigned   errs;
  int unsigned   result_idx;

  // Apply one request to the shadow queue and return what the block must say
  function automatic queue_result_t apply_request(kind_e kind, handle_t key);
    queue_result_t res;
    int            hit;
    res = '0;
    hit = -1;
    case (kind)
      KIND_APPEND: begin
        if (held_handles.size() < Depth) begin
          held_handles.push_back(key);
          res.ok = 1'b1;
        end
      end
      KIND_POP: begin
        if (held_handles.size() > 0) begin
          res.popped = held_handles.pop_front();
          res.ok     = 1'b1;
        end
      end
      default: begin
        // remove and find both look for the entry nearest the head
        for (int i = 0; i < held_handles.size(); i++) begin
          if (hit < 0 && held_handles[i] == key) hit = i;
        end
        if (hit >= 0) begin
          res.ok = 1'b1;
          if (kind == KIND_REMOVE) held_handles.delete(hit);
        end
      end
    endcase
    res.count = count_t'(held_handles.size());
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [39:0] got, logic [39:0] want);
    $display("[%0t] result %0d: %s is %0h, expected %0h", $realtime, result_idx, field,
             got, want);
    errs++;
  endtask

  // Compare results first, then predict for the request taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin : watch_b
    queue_result_t want;
    if (!rst_ni) begin
      held_handles.delete();
      due_results.delete();
      errs       = 0;
      result_idx = 0;
      err_cnt_o  <= 0;
      pending_o  <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (due_results.size() == 0) begin
          report_mismatch("unrequested result", m_tdata_i, '0);
        end else begin
          want = due_results.pop_front();
          if (m_tdata_i[31:0] !== want.popped)
            report_mismatch("popped_handle", 40'(m_tdata_i[31:0]), 40'(want.popped));
          if (m_tdata_i[32] !== want.ok)
            report_mismatch("ok", 40'(m_tdata_i[32]), 40'(want.ok));
          if (m_tdata_i[37:33] !== want.count)
            report_mismatch("entry_count", 40'(m_tdata_i[37:33]), 40'(want.count));
          if (m_tdata_i[39:38] !== 2'b00)
            report_mismatch("pad bits", 40'(m_tdata_i[39:38]), '0);
        end
        result_idx++;
      end
      if (s_tvalid_i && s_tready_i)
        due_results.push_back(apply_request(kind_e'(s_tuser_i), s_tdata_i));
      err_cnt_o <= errs;
      pending_o <= due_results.size();
    end
  end

endmodule

>>> tb/fifo_queue_with_search_remove_core_tb.sv
// ---------------------------------------------------------------------------
// fifo_queue_with_search_remove_core_tb: test top for the handle queue
// Drives directed requests (empty and full queue, duplicates, extreme
// handles, misses) and then about a thousand random requests in fill, drain
// and mixed bursts, with random gaps and stalls on both streams. The checker
// beside the block predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module fifo_queue_with_search_remove_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import fqsr_pkg::*;

  localparam int unsigned RandItems  = 1000;
  localparam int unsigned HoldCycles = 64;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned DrainWait  = 20;

  // Request mix of a random burst
  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_e;

  logic                clk_i;
  logic                rst_ni     = 1'b0;
  logic                s_tvalid_i = 1'b0;
  logic                s_tready_o;
  logic [31:0]         s_tdata_i  = '0;   // [31:0] handle
  logic [1:0]          s_tuser_i  = '0;   // [1:0] kind
  logic                m_tvalid_o;
  logic                m_tready_i = 1'b0;
  logic [OutDataW-1:0] m_tdata_o;         // [31:0] popped_handle, [32] ok,
                                          // [37:33] entry_count, [39:38] zero

  int unsigned err_cnt;
  int unsigned pend_cnt;
  bit          idle_on  = 1'b1;
  bit          hold_req = 1'b0;
  handle_t     handle_pool[8];

  fifo_queue_with_search_remove_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  fqsr_queue_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_i (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_i (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_i  (m_tdata_o),
    .err_cnt_o  (err_cnt),
    .pending_o  (pend_cnt)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one request, with a random gap first, and wait until it is taken
  task automatic send_request(kind_e kind, handle_t key);
    while (idle_on && $urandom_range(99) < 22) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= kind;
    s_tdata_i  <= key;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
  endtask

  // Fresh handles for a burst; zero and all ones turn up now and then
  task automatic refill_pool();
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(7))
        0:       handle_pool[i] = '0;
        1:       handle_pool[i] = '1;
        default: handle_pool[i] = $urandom;
      endcase
    end
  endtask

  function automatic handle_t pick_handle();
    if ($urandom_range(99) < 70) return handle_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  function automatic kind_e pick_kind(mix_e mix);
    int unsigned roll;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL:  return roll < 60 ? KIND_APPEND : roll < 70 ? KIND_POP :
                        roll < 85 ? KIND_REMOVE : KIND_FIND;
      MIX_DRAIN: return roll < 15 ? KIND_APPEND : roll < 50 ? KIND_POP :
                        roll < 80 ? KIND_REMOVE : KIND_FIND;
      default:   return kind_e'(roll[1:0]);
    endcase
  endfunction

  // Receiver: random stalls, a quiet stretch, and long hold-offs on request
  initial begin : rx_proc
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        m_tready_i <= 1'b0;
        stall_left--;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HoldCycles - 1;
        m_tready_i <= 1'b0;
      end else if (!idle_on) begin
        m_tready_i <= 1'b1;
      end else begin
        m_tready_i <= ($urandom_range(99) >= 22);
      end
    end
  end

  // Watchdog on cycles with no item moving on either stream
  initial begin : watchdog_proc
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  // Stimulus and verdict
  initial begin : stim_proc
    int unsigned sent;
    int unsigned burst_len;
    mix_e        mix;
    sent = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue: pop, find and remove all fail
    send_request(KIND_POP, 32'h0000_0000);
    send_request(KIND_FIND, 32'h0000_0000);
    send_request(KIND_REMOVE, 32'hFFFF_FFFF);
    // extremes and a duplicate
    send_request(KIND_APPEND, 32'h0000_0000);
    send_request(KIND_APPEND, 32'hFFFF_FFFF);
    send_request(KIND_APPEND, 32'h0000_0000);
    send_request(KIND_APPEND, 32'h8000_0000);
    send_request(KIND_FIND, 32'hFFFF_FFFF);
    send_request(KIND_FIND, 32'h7FFF_FFFF);
    // remove takes the duplicate at the head, the other stays
    send_request(KIND_REMOVE, 32'h0000_0000);
    send_request(KIND_FIND, 32'h0000_0000);
    send_request(KIND_REMOVE, 32'h1234_5678);
    send_request(KIND_POP, 32'hFFFF_FFFF);
    // fill to the top, one append too many, then work inside a full queue
    for (int i = 0; i < 14; i++) send_request(KIND_APPEND, 32'h1000_0000 + i);
    send_request(KIND_APPEND, 32'hA5A5_A5A5);
    send_request(KIND_REMOVE, 32'h1000_0006);
    send_request(KIND_FIND, 32'h8000_0000);
    send_request(KIND_POP, 32'h5A5A_5A5A);

    // random bursts
    while (sent < RandItems) begin
      mix       = mix_e'($urandom_range(2));
      burst_len = $urandom_range(10, 40);
      refill_pool();
      for (int j = 0; j < burst_len; j++) begin
        idle_on = !(sent >= 300 && sent < 450);
        if (sent == 500 || sent == 820) hold_req = 1'b1;
        if (sent == 650) begin
          // stop offering until the block has answered everything
          s_tvalid_i <= 1'b0;
          @(posedge clk_i);
          while (pend_cnt != 0) @(posedge clk_i);
        end
        send_request(pick_kind(mix), pick_handle());
        sent++;
      end
    end
    s_tvalid_i <= 1'b0;

    while (pend_cnt != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
